/* rtl/gic_pkg.sv */
// Package with shared widths, register codes, reset values and types of the gamepad conditioner.
`timescale 1ns / 1ps
package gic_pkg;

  localparam int PadCountDef  = 4;
  localparam int PadW         = 2;
  localparam int BtnW         = 16;
  localparam int TrigW        = 8;
  localparam int AxisW        = 16;
  localparam int AxisOutW     = 17;
  localparam int AxisCount    = 4;
  localparam int DzW          = 15;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 15;
  localparam int LtBit        = 10;
  localparam int RtBit        = 11;

  localparam int DivSteps     = 16;
  localparam int DivCntW      = $clog2(DivSteps + 1);
  localparam int DividendW    = 31;
  localparam int DivisorW     = 16;

  localparam int InDataW      = 96;
  localparam int InUserW      = 3;
  localparam int OutDataW     = 136;
  localparam int OutUserW     = 1;

  localparam logic [DzW-1:0]   DeadzoneRst = 15'd6554;
  localparam logic [TrigW-1:0] PressRst    = 8'd64;
  localparam logic [TrigW-1:0] ReleaseRst  = 8'd38;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEADZONE = 2'd0,
    CFG_PRESS    = 2'd1,
    CFG_RELEASE  = 2'd2,
    CFG_UNUSED   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            active;
    logic [BtnW-1:0] down;
    logic [BtnW-1:0] pressed;
    logic [BtnW-1:0] released;
  } btn_res_t;

endpackage

/* rtl/gic_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module gic_div
  import gic_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [DivSteps-1:0]  quotient_o
);

  logic [DivisorW-1:0] rem_q, rem_d;
  logic [DivSteps-1:0] quo_q, quo_d;
  logic [DivisorW-1:0] den_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                busy_q;
  logic                done_q;
  logic [DivisorW+1:0] trial;
  logic                fits;

  assign trial = {1'b0, rem_q, quo_q[DivSteps-1]} - {2'b00, den_q};
  assign fits  = ~trial[DivisorW+1];

  always_comb begin
    rem_d = fits ? trial[DivisorW-1:0] : {rem_q[DivisorW-2:0], quo_q[DivSteps-1]};
    quo_d = {quo_q[DivSteps-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      quo_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= ~start_i & busy_q & (cnt_q == DivCntW'(1));
      if (start_i) begin
        rem_q  <= {1'b0, dividend_i[DividendW-1:DivSteps]};
        quo_q  <= dividend_i[DivSteps-1:0];
        den_q  <= divisor_i;
        cnt_q  <= DivCntW'(DivSteps);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/gic_btn.sv */
// Per-pad button history, trigger hysteresis and edge masks.
`timescale 1ns / 1ps
module gic_btn
  import gic_pkg::*;
#(
  parameter int PAD_COUNT = PadCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             upd_i,
  input  logic [PadW-1:0]  pad_i,
  input  logic             present_i,
  input  logic [BtnW-1:0]  raw_i,
  input  logic [TrigW-1:0] lt_i,
  input  logic [TrigW-1:0] rt_i,
  input  logic [TrigW-1:0] press_i,
  input  logic [TrigW-1:0] release_i,
  output btn_res_t         res_o
);

  localparam int IdxW = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  logic [BtnW-1:0] prev_q [PAD_COUNT];
  logic            in_range;
  logic [IdxW-1:0] idx;
  logic [BtnW-1:0] prev;
  logic [BtnW-1:0] down;
  logic            lt_down;
  logic            rt_down;

  assign in_range = (int'(pad_i) < PAD_COUNT);
  assign idx      = IdxW'(pad_i);
  assign prev     = in_range ? prev_q[idx] : '0;

  always_comb begin
    lt_down = prev[LtBit] ? (lt_i > release_i) : (lt_i >= press_i);
    rt_down = prev[RtBit] ? (rt_i > release_i) : (rt_i >= press_i);
    down        = raw_i;
    down[LtBit] = lt_down;
    down[RtBit] = rt_down;
    res_o.active   = in_range & present_i;
    res_o.down     = res_o.active ? down : '0;
    res_o.pressed  = res_o.active ? (down & ~prev) : '0;
    res_o.released = res_o.active ? (prev & ~down) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAD_COUNT; i++) begin
        prev_q[i] <= '0;
      end
    end else if (upd_i && in_range) begin
      prev_q[idx] <= present_i ? down : '0;
    end
  end

endmodule

/* rtl/gamepad_input_conditioner_core.sv */
// Top level of the gamepad conditioner: stream ports, configuration and axis sequencer.
`timescale 1ns / 1ps
// One poll in, one conditioned result out. A poll is taken only while the block is idle.
// The stick axes are then worked in turn: an axis outside the deadzone takes a setup
// step in ST_LOAD, the 16 steps of the shared one-bit-per-cycle divider and a collect
// step in ST_DIV, an axis inside the deadzone is set to zero in ST_LOAD, and a poll of a
// missing or out-of-range pad skips the sticks. A finished result waits in the output
// register; the next poll is accepted once it has been handed over to that register.
// Configuration writes are taken in any cycle.
module gamepad_input_conditioner_core
  import gic_pkg::*;
#(
  parameter int PAD_COUNT = PadCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // raw_buttons, left_trigger_raw, right_trigger_raw, thumb_lx, thumb_ly, thumb_rx, thumb_ry
  input  logic [InDataW-1:0]  s_axis_tdata,
  // pad_number, pad_present
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // buttons_down, buttons_pressed, buttons_released, left_x, left_y, right_x, right_y,
  // left_trigger_level, right_trigger_level, zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // present_out
  output logic [OutUserW-1:0] m_axis_tuser
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [DzW-1:0]   dz_q;
  logic [TrigW-1:0] press_q;
  logic [TrigW-1:0] release_q;

  logic [PadW-1:0]         pad_q;
  logic                    present_q;
  logic [BtnW-1:0]         raw_q;
  logic [TrigW-1:0]        lt_q;
  logic [TrigW-1:0]        rt_q;
  logic signed [AxisW-1:0] in_axis_q [AxisCount];
  logic [1:0]              axis_cnt_q;
  logic                    neg_q;
  logic signed [AxisOutW-1:0] axis_q [AxisCount];

  logic                       out_valid_q;
  logic                       out_present_q;
  btn_res_t                   out_btn_q;
  logic signed [AxisOutW-1:0] out_axis_q [AxisCount];
  logic [TrigW-1:0]           out_lt_q;
  logic [TrigW-1:0]           out_rt_q;

  btn_res_t btn_res;
  logic     btn_upd;

  logic                 div_start;
  logic                 div_busy;
  logic                 div_done;
  logic [DivSteps-1:0]  div_quo;
  logic [DividendW-1:0] dividend;
  logic [DivisorW-1:0]  divisor;

  logic [AxisW-1:0]    cur;
  logic                cur_neg;
  logic [AxisW:0]      mag;
  logic [AxisW:0]      dz_ext;
  logic                in_dz;
  logic [AxisW-1:0]    diff;
  logic [AxisOutW-1:0] q_ext;
  logic                in_accept;
  logic                out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q      <= DeadzoneRst;
      press_q   <= PressRst;
      release_q <= ReleaseRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEADZONE: dz_q      <= cfg_data_i[DzW-1:0];
        CFG_PRESS:    press_q   <= cfg_data_i[TrigW-1:0];
        CFG_RELEASE:  release_q <= cfg_data_i[TrigW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  always_comb begin
    cur     = in_axis_q[axis_cnt_q];
    cur_neg = cur[AxisW-1];
    mag     = cur_neg ? (17'h10000 - {1'b0, cur}) : {1'b0, cur};
    if (mag == 17'd32767) begin
      mag = 17'd32768;
    end
    dz_ext   = {2'b00, dz_q};
    in_dz    = (mag <= dz_ext);
    diff     = AxisW'(mag - dz_ext);
    divisor  = DivisorW'(17'd32768 - dz_ext);
    dividend = {diff, 15'd0} + DividendW'(divisor >> 1);
    q_ext    = {1'b0, div_quo};
  end

  assign div_start = (state_q == ST_LOAD) & btn_res.active & ~in_dz;
  assign btn_upd   = (state_q == ST_FINISH) & out_free;

  gic_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  gic_btn #(
    .PAD_COUNT (PAD_COUNT)
  ) u_btn (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (btn_upd),
    .pad_i     (pad_q),
    .present_i (present_q),
    .raw_i     (raw_q),
    .lt_i      (lt_q),
    .rt_i      (rt_q),
    .press_i   (press_q),
    .release_i (release_q),
    .res_o     (btn_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pad_q         <= '0;
      present_q     <= 1'b0;
      raw_q         <= '0;
      lt_q          <= '0;
      rt_q          <= '0;
      axis_cnt_q    <= '0;
      neg_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      out_present_q <= 1'b0;
      out_btn_q     <= '0;
      out_lt_q      <= '0;
      out_rt_q      <= '0;
      for (int i = 0; i < AxisCount; i++) begin
        in_axis_q[i]  <= '0;
        axis_q[i]     <= '0;
        out_axis_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && m_axis_tready && !btn_upd) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            pad_q      <= s_axis_tuser[PadW-1:0];
            present_q  <= s_axis_tuser[PadW];
            raw_q      <= s_axis_tdata[15:0];
            lt_q       <= s_axis_tdata[23:16];
            rt_q       <= s_axis_tdata[31:24];
            for (int i = 0; i < AxisCount; i++) begin
              in_axis_q[i] <= s_axis_tdata[32 + i*AxisW +: AxisW];
            end
            axis_cnt_q <= '0;
            state_q    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (!btn_res.active) begin
            state_q <= ST_FINISH;
          end else if (in_dz) begin
            axis_q[axis_cnt_q] <= '0;
            axis_cnt_q         <= axis_cnt_q + 1'b1;
            if (axis_cnt_q == 2'(AxisCount - 1)) begin
              state_q <= ST_FINISH;
            end
          end else begin
            neg_q   <= cur_neg;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            axis_q[axis_cnt_q] <= neg_q ? -$signed(q_ext) : $signed(q_ext);
            axis_cnt_q         <= axis_cnt_q + 1'b1;
            state_q            <= (axis_cnt_q == 2'(AxisCount - 1)) ? ST_FINISH : ST_LOAD;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_present_q <= btn_res.active;
            out_btn_q     <= btn_res;
            out_lt_q      <= btn_res.active ? lt_q : '0;
            out_rt_q      <= btn_res.active ? rt_q : '0;
            for (int i = 0; i < AxisCount; i++) begin
              out_axis_q[i] <= btn_res.active ? axis_q[i] : '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_present_q;
  assign m_axis_tdata  = {4'd0, out_rt_q, out_lt_q,
                          out_axis_q[3], out_axis_q[2], out_axis_q[1], out_axis_q[0],
                          out_btn_q.released, out_btn_q.pressed, out_btn_q.down};

`ifndef SYNTHESIS
  a_div_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider result outside of divide state");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata == '0)
    else $error("result of inactive pad is not zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("poll accepted while previous poll in work");
`endif

endmodule
